// ----- rtl/smp_pkg.sv -----
// Shared types and codes for the script metadata parser.
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

   // Number of bytes in one hash of the record.
   localparam int HASH_BYTES = 32;

   // Field kinds carried on the result channel.
   localparam logic [3:0] FK_NONE     = 4'd0;
   localparam logic [3:0] FK_NAME_LEN = 4'd1;
   localparam logic [3:0] FK_ARGC     = 4'd2;
   localparam logic [3:0] FK_TYPE     = 4'd3;
   localparam logic [3:0] FK_MIN      = 4'd4;
   localparam logic [3:0] FK_MAX      = 4'd5;
   localparam logic [3:0] FK_KEY_LEN  = 4'd6;
   localparam logic [3:0] FK_INDEX    = 4'd7;
   localparam logic [3:0] FK_TSTR_LEN = 4'd8;
   localparam logic [3:0] FK_KIND     = 4'd9;

   // Record status codes.
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FORMAT = 3'd1;
   localparam logic [2:0] ST_HASHES = 3'd2;
   localparam logic [2:0] ST_SCRIPT = 3'd3;
   localparam logic [2:0] ST_ARGS   = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_HASH_W0   = 3'd0;
   localparam logic [2:0] CSR_HASH_W1   = 3'd1;
   localparam logic [2:0] CSR_HASH_W2   = 3'd2;
   localparam logic [2:0] CSR_HASH_W3   = 3'd3;
   localparam logic [2:0] CSR_ARRAY     = 3'd4;
   localparam logic [2:0] CSR_OPT_ARRAY = 3'd5;

   // Configuration seen by the parser core.
   typedef struct packed {
      logic [3:0][63:0] hash_w;
      logic [7:0]       array_code;
      logic [7:0]       opt_array_code;
   } smp_cfg_type;

   // One step result of the parser core.
   typedef struct packed {
      logic       emit;
      logic [3:0] kind;
      logic [7:0] value;
      logic [7:0] start;
      logic [4:0] argn;
      logic       done;
      logic [2:0] status;
   } smp_result_type;

endpackage

`default_nettype wire

// ----- rtl/script_metadata_parser.sv -----
// Top level of the script metadata parser: configuration, input stage and result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes a metadata record one byte per item on the req_ channel (tlast on the final
// byte) and emits one rsp_ item for each parsed field; the final byte always emits an
// item that carries the record status with tlast set. A byte is accepted every cycle
// unless rsp_ stalls; each byte passes from the input register through one step of the
// parse logic into the result register. Other bytes without a field give no result item.
// The user must write the script hash and array type codes through the csr_ channel only
// while no record is in flight; the block itself does not enforce this.
module script_metadata_parser #(
   parameter int MAX_HASHES      = 10,
   parameter int MAX_STRING      = 100,
   parameter int MAX_ARRAY_ITEMS = 20,
   parameter int MAX_ARGS        = 9,
   parameter int MAX_RECORD      = 255
) (
   input  wire         clock,
   input  wire         reset,
   // Configuration write channel.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [63:0] csr_data,
   // Record bytes in.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] meta_byte
   input  wire         req_tlast,   // is_last
   // Parsed fields out.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] field_value, [15:8] field_start,
                                    // [20:16] arg_number, [23:21] status
   output logic [3:0]  rsp_tuser,   // [3:0] field_kind
   output logic        rsp_tlast    // done_res
);
   import smp_pkg::*;

   smp_cfg_type    cfg_ff;
   smp_result_type result;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   logic [3:0]  rsp_user_ff;
   logic        rsp_last_ff;
   logic        out_free;
   logic        step_en;
   logic        req_fire;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_w         <= '0;
         cfg_ff.array_code     <= 8'd2;
         cfg_ff.opt_array_code <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HASH_W0:   cfg_ff.hash_w[0]      <= csr_data;
            CSR_HASH_W1:   cfg_ff.hash_w[1]      <= csr_data;
            CSR_HASH_W2:   cfg_ff.hash_w[2]      <= csr_data;
            CSR_HASH_W3:   cfg_ff.hash_w[3]      <= csr_data;
            CSR_ARRAY:     cfg_ff.array_code     <= csr_data[7:0];
            CSR_OPT_ARRAY: cfg_ff.opt_array_code <= csr_data[7:0];
            default:       ;
         endcase
      end
   end

   // Stage control: the byte in the input register steps once the result register is free.
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign step_en     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = out_free ? result.emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input item register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Result item register.
   always_ff @(posedge clock) begin
      if (out_free && result.emit) begin
         rsp_data_ff <= {result.status, result.argn, result.start, result.value};
         rsp_user_ff <= result.kind;
         rsp_last_ff <= result.done;
      end
   end

   smp_core #(
      .MAX_HASHES      (MAX_HASHES),
      .MAX_STRING      (MAX_STRING),
      .MAX_ARRAY_ITEMS (MAX_ARRAY_ITEMS),
      .MAX_ARGS        (MAX_ARGS),
      .MAX_RECORD      (MAX_RECORD)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (step_en),
      .byte_i  (in_byte_ff),
      .last_i  (in_last_ff),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/smp_core.sv -----
// Parse state and per-byte step logic of the script metadata parser.
`timescale 1ns / 1ps
`default_nettype none

module smp_core #(
   parameter int MAX_HASHES      = 10,
   parameter int MAX_STRING      = 100,
   parameter int MAX_ARRAY_ITEMS = 20,
   parameter int MAX_ARGS        = 9,
   parameter int MAX_RECORD      = 255
) (
   input  wire                     clock,
   input  wire                     reset,
   input  smp_pkg::smp_cfg_type    cfg,
   input  wire                     step_en,
   input  wire [7:0]               byte_i,
   input  wire                     last_i,
   output smp_pkg::smp_result_type result
);
   import smp_pkg::*;

   typedef enum logic [3:0] {
      PH_COUNT = 4'd0,
      PH_HASH  = 4'd1,
      PH_NAME  = 4'd2,
      PH_ARGC  = 4'd3,
      PH_TYPE  = 4'd4,
      PH_MIN   = 4'd5,
      PH_MAX   = 4'd6,
      PH_KEY   = 4'd7,
      PH_INDEX = 4'd8,
      PH_TSTR  = 4'd9,
      PH_KIND  = 4'd10,
      PH_DONE  = 4'd11
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [8:0] pos_ff, pos_in;
   logic [3:0] left_ff, left_in;
   logic [4:0] idx_ff, idx_in;
   logic       cur_ff, cur_in;
   logic       any_ff, any_in;
   logic [6:0] slen_ff, slen_in;
   logic [7:0] sstart_ff, sstart_in;
   logic [4:0] total_ff, total_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [7:0] amin_ff, amin_in;
   logic [2:0] err_ff, err_in;

   logic [63:0] hash_word;
   logic [7:0]  hash_byte;
   logic        cur_v;
   logic [3:0]  kind;
   logic [7:0]  value;
   logic [7:0]  start;
   logic [4:0]  argn;
   logic [2:0]  status;

   // Script hash byte for the current hash position; byte 0 of a word is its top byte.
   assign hash_word = cfg.hash_w[idx_ff[4:3]];
   assign hash_byte = hash_word[{~idx_ff[2:0], 3'b000} +: 8];

   // One parse step for the byte at the stage input.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      any_in    = any_ff;
      slen_in   = slen_ff;
      sstart_in = sstart_ff;
      total_in  = total_ff;
      cnt_in    = cnt_ff;
      amin_in   = amin_ff;
      err_in    = err_ff;
      cur_v     = 1'b0;
      kind      = FK_NONE;
      value     = '0;
      start     = '0;
      argn      = '0;
      status    = ST_OK;
      if (step_en) begin
         if (err_ff == ST_OK && pos_ff >= 9'(MAX_RECORD)) begin
            err_in = ST_FORMAT;
         end
         if (err_in == ST_OK) begin
            pos_in = pos_ff + 9'd1;
            unique case (phase_ff)
               PH_COUNT: begin
                  if (byte_i > 8'(MAX_HASHES)) begin
                     err_in = ST_HASHES;
                  end else if (byte_i == 8'd0) begin
                     err_in = ST_SCRIPT;
                  end else begin
                     left_in  = byte_i[3:0];
                     idx_in   = '0;
                     cur_in   = 1'b1;
                     phase_in = PH_HASH;
                  end
               end
               PH_HASH: begin
                  cur_v = cur_ff & (byte_i == hash_byte);
                  if (idx_ff == 5'(HASH_BYTES - 1)) begin
                     any_in  = any_ff | cur_v;
                     cur_in  = 1'b1;
                     idx_in  = '0;
                     left_in = left_ff - 4'd1;
                     if (left_ff == 4'd1) begin
                        if (any_in) begin
                           phase_in = PH_NAME;
                           slen_in  = '0;
                        end else begin
                           err_in = ST_SCRIPT;
                        end
                     end
                  end else begin
                     cur_in = cur_v;
                     idx_in = idx_ff + 5'd1;
                  end
               end
               PH_NAME, PH_KEY, PH_TSTR: begin
                  if (slen_ff == 7'd0 && byte_i != 8'd0) begin
                     sstart_in = pos_ff[7:0];
                  end
                  if (byte_i == 8'd0) begin
                     // Terminator: an empty string starts at the terminator itself.
                     if (slen_ff == 7'd0) begin
                        sstart_in = pos_ff[7:0];
                     end
                     value   = {1'b0, slen_ff};
                     start   = sstart_in;
                     slen_in = '0;
                     if (phase_ff == PH_NAME) begin
                        kind     = FK_NAME_LEN;
                        phase_in = PH_ARGC;
                     end else if (phase_ff == PH_KEY) begin
                        kind     = FK_KEY_LEN;
                        argn     = cnt_ff;
                        phase_in = PH_INDEX;
                     end else begin
                        kind     = FK_TSTR_LEN;
                        argn     = cnt_ff;
                        phase_in = PH_KIND;
                     end
                  end else if (slen_ff >= 7'(MAX_STRING)) begin
                     err_in = ST_FORMAT;
                  end else begin
                     slen_in = slen_ff + 7'd1;
                  end
               end
               PH_ARGC: begin
                  if (byte_i > 8'(MAX_ARGS)) begin
                     err_in = ST_ARGS;
                  end else begin
                     kind     = FK_ARGC;
                     value    = byte_i;
                     total_in = byte_i[4:0];
                     cnt_in   = '0;
                     phase_in = (byte_i == 8'd0) ? PH_DONE : PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  kind  = FK_TYPE;
                  value = byte_i;
                  argn  = cnt_ff;
                  if (byte_i == cfg.array_code || byte_i == cfg.opt_array_code) begin
                     phase_in = PH_MIN;
                  end else begin
                     phase_in = PH_KEY;
                     slen_in  = '0;
                  end
               end
               PH_MIN: begin
                  kind     = FK_MIN;
                  value    = byte_i;
                  argn     = cnt_ff;
                  amin_in  = byte_i;
                  phase_in = PH_MAX;
               end
               PH_MAX: begin
                  if (amin_ff > byte_i || byte_i > 8'(MAX_ARRAY_ITEMS)) begin
                     err_in = ST_FORMAT;
                  end else begin
                     kind     = FK_MAX;
                     value    = byte_i;
                     argn     = cnt_ff;
                     phase_in = PH_KEY;
                     slen_in  = '0;
                  end
               end
               PH_INDEX: begin
                  kind     = FK_INDEX;
                  value    = byte_i;
                  argn     = cnt_ff;
                  phase_in = PH_TSTR;
                  slen_in  = '0;
               end
               PH_KIND: begin
                  kind     = FK_KIND;
                  value    = byte_i;
                  argn     = cnt_ff;
                  cnt_in   = cnt_ff + 5'd1;
                  phase_in = (cnt_in >= total_ff) ? PH_DONE : PH_TYPE;
               end
               default: begin
                  // A byte after the record is complete.
                  err_in = ST_FORMAT;
               end
            endcase
            if (err_in != ST_OK) begin
               kind  = FK_NONE;
               value = '0;
               start = '0;
               argn  = '0;
            end
         end
         // The last byte reports the status and rearms the parser.
         if (last_i) begin
            if (err_in == ST_OK && phase_in != PH_DONE) begin
               status = ST_FORMAT;
            end else begin
               status = err_in;
            end
            phase_in  = PH_COUNT;
            pos_in    = '0;
            left_in   = '0;
            idx_in    = '0;
            cur_in    = 1'b1;
            any_in    = 1'b0;
            slen_in   = '0;
            sstart_in = '0;
            total_in  = '0;
            cnt_in    = '0;
            amin_in   = '0;
            err_in    = ST_OK;
         end
      end
   end

   // Result of this step.
   always_comb begin
      result.emit   = step_en && (last_i || kind != FK_NONE);
      result.kind   = kind;
      result.value  = value;
      result.start  = start;
      result.argn   = argn;
      result.done   = last_i;
      result.status = status;
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_COUNT;
         pos_ff    <= '0;
         left_ff   <= '0;
         idx_ff    <= '0;
         cur_ff    <= 1'b1;
         any_ff    <= 1'b0;
         slen_ff   <= '0;
         sstart_ff <= '0;
         total_ff  <= '0;
         cnt_ff    <= '0;
         amin_ff   <= '0;
         err_ff    <= ST_OK;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         left_ff   <= left_in;
         idx_ff    <= idx_in;
         cur_ff    <= cur_in;
         any_ff    <= any_in;
         slen_ff   <= slen_in;
         sstart_ff <= sstart_in;
         total_ff  <= total_in;
         cnt_ff    <= cnt_in;
         amin_ff   <= amin_in;
         err_ff    <= err_in;
      end
   end

endmodule

`default_nettype wire
